// ===== sv/fslr_pkg.sv =====
// ----------------------------------------------------------------------------
// fslr_pkg
// Shared types and constants for the framed serial link receiver: register
// map, reset values, command codes passed from the parser to the emitter.
// ----------------------------------------------------------------------------
package fslr_pkg;

    // Register map
    localparam logic [2:0] REG_TICK_PERIOD    = 3'd0;
    localparam logic [2:0] REG_HEADER_CODE    = 3'd1;
    localparam logic [2:0] REG_FOOTER_CODE    = 3'd2;
    localparam logic [2:0] REG_HANDSHAKE_CODE = 3'd3;
    localparam logic [2:0] REG_HEARTBEAT_CODE = 3'd4;
    localparam logic [2:0] REG_IDENTITY_CHARS = 3'd5;
    localparam logic [2:0] REG_IDENTITY_LEN   = 3'd6;

    // Register reset values
    localparam logic [9:0] RST_TICK_PERIOD    = 10'd10;
    localparam logic [7:0] RST_HEADER_CODE    = 8'd1;
    localparam logic [7:0] RST_FOOTER_CODE    = 8'd4;
    localparam logic [7:0] RST_HANDSHAKE_CODE = 8'd5;
    localparam logic [7:0] RST_HEARTBEAT_CODE = 8'd6;

    // Timing thresholds in milliseconds
    localparam int HEARTBEAT_MS    = 250;
    localparam int IDLE_TIMEOUT_MS = 1000;

    // Saturation limits of the tick counters
    localparam logic [7:0] HB_TICKS_MAX   = 8'd255;
    localparam logic [9:0] IDLE_TICKS_MAX = 10'd1023;

    // Longest identity name in bytes
    localparam logic [3:0] IDENT_MAX = 4'd8;

    // Command queue depth between parser and emitter
    localparam int QUEUE_DEPTH = 4;

    // Input command field
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Parser phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_FOOTER  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_FEND    = 2'd2;
    localparam logic [1:0] KIND_RESET   = 2'd3;

    // Emitter operations
    localparam logic [1:0] OP_IDENT   = 2'd0;
    localparam logic [1:0] OP_PAYLOAD = 2'd1;
    localparam logic [1:0] OP_FEND    = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // Configuration register file contents
    typedef struct packed {
        logic [9:0]  tick_period_ms;
        logic [7:0]  header_code;
        logic [7:0]  footer_code;
        logic [7:0]  handshake_code;
        logic [7:0]  heartbeat_code;
        logic [63:0] identity_chars;
        logic [3:0]  identity_length;
    } t_cfg;

    // One queued command; flag_a is footer-ok or heartbeat, flag_b is reset
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic [7:0] index;
        logic       flag_a;
        logic       flag_b;
    } t_cmd;

endpackage

// ===== sv/framed_serial_link_receiver.sv =====
// Path: an accepted input transaction is written into the command queue, and
// its result is then loaded from the queue head into the output register.
// Throughput: one input transaction per cycle while the queue is not full; one
// result per cycle while output is not stalled; a handshake reply of N bytes is N+3 items.
// Reset: synchronous, active low; clears parser state, queue and output stage,
// and sets the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// framed_serial_link_receiver
// Length-prefixed frame deframer with identity handshake reply, heartbeat
// transmit and idle watchdog. Parser front end, command queue, emitter.
// ----------------------------------------------------------------------------
module framed_serial_link_receiver #(
    parameter int QUEUE_DEPTH = fslr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transactions
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_rx_byte,
    // Result transactions
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_payload_index,
    output logic        o_frame_ok,
    output logic        o_last,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    fslr_pkg::t_cfg r_cfg;
    fslr_pkg::t_cmd push_cmd;
    fslr_pkg::t_cmd head;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;
    logic           in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid & ~q_full;

    // Configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_period_ms  <= fslr_pkg::RST_TICK_PERIOD;
            r_cfg.header_code     <= fslr_pkg::RST_HEADER_CODE;
            r_cfg.footer_code     <= fslr_pkg::RST_FOOTER_CODE;
            r_cfg.handshake_code  <= fslr_pkg::RST_HANDSHAKE_CODE;
            r_cfg.heartbeat_code  <= fslr_pkg::RST_HEARTBEAT_CODE;
            r_cfg.identity_chars  <= 64'd0;
            r_cfg.identity_length <= 4'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                fslr_pkg::REG_TICK_PERIOD:    r_cfg.tick_period_ms  <= i_cfg_data[9:0];
                fslr_pkg::REG_HEADER_CODE:    r_cfg.header_code     <= i_cfg_data[7:0];
                fslr_pkg::REG_FOOTER_CODE:    r_cfg.footer_code     <= i_cfg_data[7:0];
                fslr_pkg::REG_HANDSHAKE_CODE: r_cfg.handshake_code  <= i_cfg_data[7:0];
                fslr_pkg::REG_HEARTBEAT_CODE: r_cfg.heartbeat_code  <= i_cfg_data[7:0];
                fslr_pkg::REG_IDENTITY_CHARS: r_cfg.identity_chars  <= i_cfg_data;
                fslr_pkg::REG_IDENTITY_LEN:   r_cfg.identity_length <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Parser front end
    fslr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (in_accept),
        .i_cmd      (i_cmd),
        .i_rx_byte  (i_rx_byte),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    // Command queue
    fslr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (q_empty),
        .o_full     (q_full)
    );

    // Result emitter
    fslr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head          (head),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_payload_index (o_payload_index),
        .o_frame_ok      (o_frame_ok),
        .o_last          (o_last)
    );

endmodule

// ===== sv/fslr_front.sv =====
// ----------------------------------------------------------------------------
// fslr_front
// Accepts bytes and ticks, runs the deframer, heartbeat and watchdog
// counters, and turns each item that has output into one queued command.
// ----------------------------------------------------------------------------
module fslr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fslr_pkg::t_cfg        i_cfg,
    input  logic                  i_accept,
    input  logic                  i_cmd,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_push,
    output fslr_pkg::t_cmd        o_push_cmd
);

    logic [1:0]  r_phase,     n_phase;
    logic [7:0]  r_count,     n_count;
    logic [7:0]  r_length,    n_length;
    logic [7:0]  r_hb_ticks,  n_hb_ticks;
    logic [9:0]  r_idle,      n_idle;
    logic        r_byte_seen, n_byte_seen;

    logic [7:0]  hb_inc;
    logic [9:0]  idle_inc;
    logic [17:0] hb_prod;
    logic [19:0] idle_prod;
    logic        hb_fire;
    logic        wd_fire;
    logic [7:0]  count_inc;

    // Tick arithmetic
    assign hb_inc    = (r_hb_ticks < fslr_pkg::HB_TICKS_MAX) ? r_hb_ticks + 8'd1 : r_hb_ticks;
    assign idle_inc  = r_byte_seen ? 10'd0 :
                       ((r_idle < fslr_pkg::IDLE_TICKS_MAX) ? r_idle + 10'd1 : r_idle);
    assign hb_prod   = 18'(hb_inc) * 18'(i_cfg.tick_period_ms);
    assign idle_prod = 20'(idle_inc) * 20'(i_cfg.tick_period_ms);
    assign hb_fire   = hb_prod > 18'(fslr_pkg::HEARTBEAT_MS);
    assign wd_fire   = idle_prod > 20'(fslr_pkg::IDLE_TIMEOUT_MS);
    assign count_inc = r_count + 8'd1;

    // Next state and command
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_length    = r_length;
        n_hb_ticks  = r_hb_ticks;
        n_idle      = r_idle;
        n_byte_seen = r_byte_seen;
        o_push      = 1'b0;
        o_push_cmd  = '0;

        if (i_accept) begin
            if (i_cmd == fslr_pkg::CMD_BYTE) begin
                n_byte_seen = 1'b1;
                case (r_phase)
                    fslr_pkg::PH_HEADER: begin
                        if (i_rx_byte == i_cfg.header_code) begin
                            n_phase = fslr_pkg::PH_LENGTH;
                        end else if (i_rx_byte == i_cfg.handshake_code) begin
                            o_push        = 1'b1;
                            o_push_cmd.op = fslr_pkg::OP_IDENT;
                        end
                    end
                    fslr_pkg::PH_LENGTH: begin
                        n_length = i_rx_byte;
                        n_count  = 8'd0;
                        n_phase  = (i_rx_byte == 8'd0) ? fslr_pkg::PH_FOOTER
                                                       : fslr_pkg::PH_PAYLOAD;
                    end
                    fslr_pkg::PH_PAYLOAD: begin
                        o_push           = 1'b1;
                        o_push_cmd.op    = fslr_pkg::OP_PAYLOAD;
                        o_push_cmd.data  = i_rx_byte;
                        o_push_cmd.index = r_count;
                        n_count          = count_inc;
                        if (count_inc >= r_length) begin
                            n_phase = fslr_pkg::PH_FOOTER;
                        end
                    end
                    default: begin
                        o_push            = 1'b1;
                        o_push_cmd.op     = fslr_pkg::OP_FEND;
                        o_push_cmd.data   = r_length;
                        o_push_cmd.flag_a = (i_rx_byte == i_cfg.footer_code);
                        n_phase           = fslr_pkg::PH_HEADER;
                    end
                endcase
            end else begin
                // Tick: heartbeat counter, then watchdog
                n_hb_ticks  = hb_fire ? 8'd0 : hb_inc;
                n_idle      = idle_inc;
                n_byte_seen = 1'b0;
                o_push            = hb_fire | wd_fire;
                o_push_cmd.op     = fslr_pkg::OP_TICK;
                o_push_cmd.flag_a = hb_fire;
                o_push_cmd.flag_b = wd_fire;
                if (wd_fire) begin
                    n_phase     = fslr_pkg::PH_HEADER;
                    n_count     = 8'd0;
                    n_length    = 8'd0;
                    n_hb_ticks  = 8'd0;
                    n_idle      = 10'd0;
                    n_byte_seen = 1'b0;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= fslr_pkg::PH_HEADER;
            r_count     <= 8'd0;
            r_length    <= 8'd0;
            r_hb_ticks  <= 8'd0;
            r_idle      <= 10'd0;
            r_byte_seen <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_length    <= n_length;
            r_hb_ticks  <= n_hb_ticks;
            r_idle      <= n_idle;
            r_byte_seen <= n_byte_seen;
        end
    end

endmodule

// ===== sv/fslr_queue.sv =====
// ----------------------------------------------------------------------------
// fslr_queue
// Short command FIFO between the parser and the emitter; the head entry is
// visible without a pop so the emitter can expand it into several results.
// ----------------------------------------------------------------------------
module fslr_queue #(
    parameter int DEPTH = fslr_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  fslr_pkg::t_cmd        i_push_cmd,
    input  logic                  i_pop,
    output fslr_pkg::t_cmd        o_head,
    output logic                  o_empty,
    output logic                  o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fslr_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_empty = (r_count == CW'(0));
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== sv/fslr_back.sv =====
// ----------------------------------------------------------------------------
// fslr_back
// Expands queued commands into result items, one per cycle, into a
// registered output stage with stall.
// ----------------------------------------------------------------------------
module fslr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fslr_pkg::t_cfg        i_cfg,
    input  fslr_pkg::t_cmd        i_head,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_data_byte,
    output logic [7:0]            o_payload_index,
    output logic                  o_frame_ok,
    output logic                  o_last
);

    logic [3:0] r_step;
    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_data;
    logic [7:0] r_index;
    logic       r_ok;
    logic       r_last;

    logic       load;
    logic [3:0] id_len;
    logic [2:0] char_sel;
    logic [1:0] n_kind;
    logic [7:0] n_data;
    logic [7:0] n_index;
    logic       n_ok;
    logic       n_last;

    assign load     = ~i_empty & (~r_valid | ~i_out_stall);
    assign id_len   = (i_cfg.identity_length > fslr_pkg::IDENT_MAX) ? fslr_pkg::IDENT_MAX
                                                                      : i_cfg.identity_length;
    assign char_sel = 3'(r_step - 4'd2);
    assign o_pop    = load & n_last;

    // Result for the current step of the head command
    always_comb begin
        n_kind  = fslr_pkg::KIND_TX;
        n_data  = 8'd0;
        n_index = 8'd0;
        n_ok    = 1'b0;
        n_last  = 1'b1;
        case (i_head.op)
            fslr_pkg::OP_IDENT: begin
                n_last = (r_step == id_len + 4'd2);
                if (r_step == 4'd0) begin
                    n_data = i_cfg.header_code;
                end else if (r_step == 4'd1) begin
                    n_data = 8'(id_len);
                end else if (n_last) begin
                    n_data = i_cfg.footer_code;
                end else begin
                    n_data = i_cfg.identity_chars[8*char_sel +: 8];
                end
            end
            fslr_pkg::OP_PAYLOAD: begin
                n_kind  = fslr_pkg::KIND_PAYLOAD;
                n_data  = i_head.data;
                n_index = i_head.index;
            end
            fslr_pkg::OP_FEND: begin
                n_kind = fslr_pkg::KIND_FEND;
                n_data = i_head.data;
                n_ok   = i_head.flag_a;
            end
            default: begin
                // Heartbeat byte first, then the reset request
                if (i_head.flag_a && r_step == 4'd0) begin
                    n_data = i_cfg.heartbeat_code;
                    n_last = ~i_head.flag_b;
                end else begin
                    n_kind = fslr_pkg::KIND_RESET;
                end
            end
        endcase
    end

    // Step counter and output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step  <= n_last ? 4'd0 : r_step + 4'd1;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_data  <= n_data;
            r_index <= n_index;
            r_ok    <= n_ok;
            r_last  <= n_last;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_kind          = r_kind;
    assign o_data_byte     = r_data;
    assign o_payload_index = r_index;
    assign o_frame_ok      = r_ok;
    assign o_last          = r_last;

endmodule
